/* hw/rtl/assert_macros.svh */
// Assertion shorthands used by the decompressor RTL.
// Every property is sampled on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/lzd_pkg.sv */
`timescale 1ns / 1ps

package lzd_pkg;

  // Default token geometry.
  localparam int OFFSET_BITS_DEF = 13;
  localparam int LENGTH_BITS_DEF = 4;

  // A match copies its length field plus this many bytes.
  localparam int MIN_MATCH = 3;

  localparam int BYTE_W  = 8;
  localparam int LIMIT_W = 24;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

  // Token events raised by the bit parser on the bit that completes a field.
  typedef struct packed {
    logic lit;    // literal byte complete
    logic eos;    // zero offset: end of stream
    logic match;  // length field complete, copy may start
  } tok_t;

endpackage

/* hw/rtl/lzd_bit_parser.sv */
`timescale 1ns / 1ps

module lzd_bit_parser #(
  parameter int OFFSET_BITS = lzd_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = lzd_pkg::LENGTH_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clr,       // start of a new stream
  input  logic                      bit_en,    // one code bit is taken this cycle
  input  logic                      bit_in,
  output lzd_pkg::tok_t             tok,
  output logic [lzd_pkg::BYTE_W-1:0] lit_byte,
  output logic [LENGTH_BITS-1:0]    len_val,
  output logic [OFFSET_BITS-1:0]    held_off
);

  // The offset is the widest field, so it sets the accumulator width.
  localparam int ACC_W = OFFSET_BITS;
  localparam int CNT_W = $clog2(OFFSET_BITS + 1);

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LITERAL,
    PH_OFFSET,
    PH_LENGTH
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   needed_r, needed_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [ACC_W-1:0]   shifted;
  logic               last_bit;

  // Shift the new bit in and see whether it completes the current field.
  assign shifted  = {acc_r[ACC_W-2:0], bit_in};
  assign last_bit = (needed_r == CNT_W'(1));

  assign lit_byte = shifted[lzd_pkg::BYTE_W-1:0];
  assign len_val  = shifted[LENGTH_BITS-1:0];
  assign held_off = off_r;

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    needed_nxt = needed_r;
    off_nxt    = off_r;
    tok        = '0;
    if (bit_en) begin
      if (!last_bit) begin
        acc_nxt    = shifted;
        needed_nxt = needed_r - CNT_W'(1);
      end else begin
        acc_nxt = '0;
        case (phase_r)
          PH_FLAG: begin
            if (bit_in) begin
              phase_nxt  = PH_LITERAL;
              needed_nxt = CNT_W'(lzd_pkg::BYTE_W);
            end else begin
              phase_nxt  = PH_OFFSET;
              needed_nxt = CNT_W'(OFFSET_BITS);
            end
          end
          PH_LITERAL: begin
            tok.lit    = 1'b1;
            phase_nxt  = PH_FLAG;
            needed_nxt = CNT_W'(1);
          end
          PH_OFFSET: begin
            if (shifted == '0) begin
              tok.eos = 1'b1;
            end else begin
              off_nxt    = shifted;
              phase_nxt  = PH_LENGTH;
              needed_nxt = CNT_W'(LENGTH_BITS);
            end
          end
          PH_LENGTH: begin
            tok.match  = 1'b1;
            phase_nxt  = PH_FLAG;
            needed_nxt = CNT_W'(1);
          end
          default: begin
            phase_nxt  = PH_FLAG;
            needed_nxt = CNT_W'(1);
          end
        endcase
      end
    end
  end

  // Parser state; a new stream puts it back to waiting for a flag bit.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      phase_r  <= PH_FLAG;
      acc_r    <= '0;
      needed_r <= CNT_W'(1);
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      needed_r <= needed_nxt;
    end
    off_r <= off_nxt;
  end

endmodule

/* hw/rtl/lzss_decompressor.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake             Payload
// in_*      in   in_tvalid/in_tready   tdata = comp_byte, tlast = final_byte
// out_*     out  out_tvalid/out_tready tdata = data_byte, tlast = run_end,
//                                      tuser = {stream_done, has_data}
// cfg_*     in   cfg_wr_en             cfg_wr_data = output_limit
//
// After reset the dictionary is cleared one entry a cycle, every entry in turn, in_tready low.
// A word: accept, one code bit per unstalled cycle, end-of-bits check, flush of its results.
// A copied byte adds a read and a write state, and each copy a further read state to finish.
// An end of stream skips the rest of the word; a final word feeds zero bits, one per unstalled cycle.
// Stalls on out_tready pause the sequencer only when holding slot and output register are full.

module lzss_decompressor #(
  parameter int OFFSET_BITS = lzd_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = lzd_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Compressed input.
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] comp_byte
  input  logic                        in_tlast,   // final_byte
  // Decompressed output.
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] data_byte
  output logic [1:0]                  out_tuser,  // [0] has_data, [1] stream_done
  output logic                        out_tlast,  // run_end
  // Output limit register.
  input  logic                        cfg_wr_en,
  input  logic [lzd_pkg::LIMIT_W-1:0] cfg_wr_data
);

  `include "assert_macros.svh"

  localparam int DICT_DEPTH = 1 << OFFSET_BITS;
  localparam int CPY_W      = LENGTH_BITS + 1;
  localparam int BW         = lzd_pkg::BYTE_W;
  localparam int LW         = lzd_pkg::LIMIT_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BITS,
    ST_RD,
    ST_WR,
    ST_FLUSH
  } state_t;

  // Sequencer and stream state.
  state_t                 state_r, state_nxt;
  logic [OFFSET_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic [BW-1:0]          byte_r, byte_nxt;
  logic                   final_r, final_nxt;
  logic [3:0]             bit_left_r, bit_left_nxt;
  logic [OFFSET_BITS-1:0] ring_r, ring_nxt;
  logic [LW-1:0]          emitted_r, emitted_nxt;
  logic                   done_r, done_nxt;
  logic [LW-1:0]          limit_r, limit_nxt;
  logic [CPY_W-1:0]       cnt_r, cnt_nxt;
  logic [OFFSET_BITS-1:0] cpy_addr_r, cpy_addr_nxt;

  // Holding slot and output register.
  logic                   hold_v_r, hold_v_nxt;
  logic [BW-1:0]          hold_data_r, hold_data_nxt;
  logic                   hold_has_r, hold_has_nxt;
  logic                   hold_done_r, hold_done_nxt;
  logic                   out_v_r, out_v_nxt;
  logic [BW-1:0]          out_data_r, out_data_nxt;
  logic                   out_has_r, out_has_nxt;
  logic                   out_done_r, out_done_nxt;
  logic                   out_last_r, out_last_nxt;

  // Dictionary.
  logic [BW-1:0]          dict_mem [DICT_DEPTH];
  logic [BW-1:0]          rd_data_r;
  logic                   dict_we;
  logic [OFFSET_BITS-1:0] dict_wa;
  logic [BW-1:0]          dict_wd;
  logic                   dict_re;

  // Parser interface.
  logic                   par_clr;
  logic                   bit_en;
  lzd_pkg::tok_t          tok;
  logic [BW-1:0]          lit_byte;
  logic [LENGTH_BITS-1:0] len_val;
  logic [OFFSET_BITS-1:0] held_off;

  // Helpers.
  logic                   in_acc;
  logic                   step_ok;
  logic                   have_bit;
  logic                   lim_hit;
  logic                   push;
  logic [BW-1:0]          push_data;
  logic                   push_has;
  logic                   push_done;

  lzd_bit_parser #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (par_clr),
    .bit_en   (bit_en),
    .bit_in   (byte_r[BW-1]),
    .tok      (tok),
    .lit_byte (lit_byte),
    .len_val  (len_val),
    .held_off (held_off)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_done_r, out_has_r};
  assign out_tlast  = out_last_r;

  // A step may produce a result only if the holding slot can drain.
  assign step_ok  = !hold_v_r || !out_v_r || out_tready;
  assign have_bit = (bit_left_r != 4'd0) || final_r;
  assign lim_hit  = (emitted_r >= limit_r);
  assign bit_en   = (state_r == ST_BITS) && have_bit && step_ok;
  assign par_clr  = in_acc && done_r;
  assign dict_re  = (state_r == ST_RD) && (cnt_r != '0) && !lim_hit;

  // Sequencer next state.
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    byte_nxt     = byte_r;
    final_nxt    = final_r;
    bit_left_nxt = bit_left_r;
    ring_nxt     = ring_r;
    emitted_nxt  = emitted_r;
    done_nxt     = done_r;
    limit_nxt    = cfg_wr_en ? cfg_wr_data : limit_r;
    cnt_nxt      = cnt_r;
    cpy_addr_nxt = cpy_addr_r;
    push         = 1'b0;
    push_data    = '0;
    push_has     = 1'b0;
    push_done    = 1'b0;
    dict_we      = 1'b0;
    dict_wa      = ring_r;
    dict_wd      = '0;
    case (state_r)
      ST_CLEAR: begin
        dict_we      = 1'b1;
        dict_wa      = clr_addr_r;
        clr_addr_nxt = clr_addr_r + OFFSET_BITS'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          byte_nxt     = in_tdata;
          final_nxt    = in_tlast;
          bit_left_nxt = 4'd8;
          state_nxt    = ST_BITS;
          if (done_r) begin
            ring_nxt    = OFFSET_BITS'(1);
            emitted_nxt = '0;
            done_nxt    = 1'b0;
          end
        end
      end
      ST_BITS: begin
        if (!have_bit) begin
          state_nxt = ST_FLUSH;
        end else if (step_ok) begin
          byte_nxt = {byte_r[BW-2:0], 1'b0};
          if (bit_left_r != 4'd0) begin
            bit_left_nxt = bit_left_r - 4'd1;
          end
          if (tok.eos || (tok.lit && lim_hit)) begin
            push      = 1'b1;
            push_done = 1'b1;
            done_nxt  = 1'b1;
            state_nxt = ST_FLUSH;
          end else if (tok.lit) begin
            push        = 1'b1;
            push_data   = lit_byte;
            push_has    = 1'b1;
            dict_we     = 1'b1;
            dict_wd     = lit_byte;
            ring_nxt    = ring_r + OFFSET_BITS'(1);
            emitted_nxt = emitted_r + LW'(1);
          end else if (tok.match) begin
            cnt_nxt      = {1'b0, len_val} + CPY_W'(lzd_pkg::MIN_MATCH);
            cpy_addr_nxt = held_off;
            state_nxt    = ST_RD;
          end
        end
      end
      ST_RD: begin
        // Copies past the limit are dropped; parsing goes on.
        if (dict_re) begin
          state_nxt = ST_WR;
        end else begin
          state_nxt = ST_BITS;
        end
      end
      ST_WR: begin
        if (step_ok) begin
          push         = 1'b1;
          push_data    = rd_data_r;
          push_has     = 1'b1;
          dict_we      = 1'b1;
          dict_wd      = rd_data_r;
          ring_nxt     = ring_r + OFFSET_BITS'(1);
          emitted_nxt  = emitted_r + LW'(1);
          cpy_addr_nxt = cpy_addr_r + OFFSET_BITS'(1);
          cnt_nxt      = cnt_r - CPY_W'(1);
          state_nxt    = ST_RD;
        end
      end
      ST_FLUSH: begin
        if (!hold_v_r || !out_v_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result path: a new result pushes the held one out; the last one leaves at word end.
  always_comb begin
    hold_v_nxt    = hold_v_r;
    hold_data_nxt = hold_data_r;
    hold_has_nxt  = hold_has_r;
    hold_done_nxt = hold_done_r;
    out_v_nxt     = out_v_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_has_nxt   = out_has_r;
    out_done_nxt  = out_done_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      if (hold_v_r) begin
        out_v_nxt    = 1'b1;
        out_data_nxt = hold_data_r;
        out_has_nxt  = hold_has_r;
        out_done_nxt = hold_done_r;
        out_last_nxt = 1'b0;
      end
      hold_v_nxt    = 1'b1;
      hold_data_nxt = push_data;
      hold_has_nxt  = push_has;
      hold_done_nxt = push_done;
    end else if ((state_r == ST_FLUSH) && hold_v_r && (!out_v_r || out_tready)) begin
      out_v_nxt    = 1'b1;
      out_data_nxt = hold_data_r;
      out_has_nxt  = hold_has_r;
      out_done_nxt = hold_done_r;
      out_last_nxt = 1'b1;
      hold_v_nxt   = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      bit_left_r <= '0;
      final_r    <= 1'b0;
      ring_r     <= OFFSET_BITS'(1);
      emitted_r  <= '0;
      done_r     <= 1'b0;
      limit_r    <= lzd_pkg::LIMIT_RESET;
      cnt_r      <= '0;
      hold_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      bit_left_r <= bit_left_nxt;
      final_r    <= final_nxt;
      ring_r     <= ring_nxt;
      emitted_r  <= emitted_nxt;
      done_r     <= done_nxt;
      limit_r    <= limit_nxt;
      cnt_r      <= cnt_nxt;
      hold_v_r   <= hold_v_nxt;
      out_v_r    <= out_v_nxt;
    end
    byte_r      <= byte_nxt;
    cpy_addr_r  <= cpy_addr_nxt;
    hold_data_r <= hold_data_nxt;
    hold_has_r  <= hold_has_nxt;
    hold_done_r <= hold_done_nxt;
    out_data_r  <= out_data_nxt;
    out_has_r   <= out_has_nxt;
    out_done_r  <= out_done_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Dictionary: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (dict_we) begin
      dict_mem[dict_wa] <= dict_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (dict_re) begin
      rd_data_r <= dict_mem[cpy_addr_r];
    end
  end

  // A new word is never taken with a result still in the holding slot.
  `ASSERT_CLK(a_ready_hold_empty, in_tready |-> !hold_v_r, "word accepted with result held")
  // The stream marker always closes the run of its word.
  `ASSERT_CLK(a_marker_last, out_tvalid && out_tuser[1] |-> out_tlast && !out_tuser[0],
    "stream marker not last or carries data")
  // A dictionary read cycle never counts an output byte.
  `ASSERT_CLK(a_rd_no_emit, state_r == ST_RD |=> emitted_r == $past(emitted_r),
    "byte counted during dictionary read")
  // Once the stream is done no copy is in flight.
  `ASSERT_NEVER(a_done_no_copy, done_r && (state_r == ST_RD || state_r == ST_WR),
    "copy running after stream end")

endmodule

/* bench/tb_lzss_decompressor.sv */
`timescale 1ns / 1ps

module tb_lzss_decompressor;

  localparam int OFF_W          = lzd_pkg::OFFSET_BITS_DEF;
  localparam int LEN_W          = lzd_pkg::LENGTH_BITS_DEF;
  localparam int BYTE_W         = lzd_pkg::BYTE_W;
  localparam int LIM_W          = lzd_pkg::LIMIT_W;
  localparam int DICT_DEPTH     = 1 << OFF_W;
  localparam int FILL_GUARD     = 4 * (OFF_W + LEN_W + 10);
  localparam int SETTLE_CYCLES  = 300;
  localparam int HOLD_CYCLES    = 600;
  localparam int PHASE_WORDS    = 65;
  localparam int PRESSURE_WORDS = 25;
  localparam longint TIMEOUT_NS = 4_000_000;

  // Parser position inside a token.
  typedef enum logic [1:0] {
    FIELD_FLAG,
    FIELD_LITERAL,
    FIELD_OFFSET,
    FIELD_LENGTH
  } field_t;

  // One output word as the decoder is expected to produce it.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              has_data;
    logic              run_end;
    logic              stream_done;
  } out_word_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // [7:0] comp_byte
  logic                in_tlast;   // final_byte
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;  // [7:0] data_byte
  logic [1:0]          out_tuser;  // [0] has_data, [1] stream_done
  logic                out_tlast;  // run_end
  logic                cfg_wr_en;
  logic [LIM_W-1:0]    cfg_wr_data;

  // Decoder state mirrored by the testbench.
  logic [BYTE_W-1:0]   dict_mem [DICT_DEPTH];
  logic [OFF_W-1:0]    ring_pos;
  logic [15:0]         bit_acc;
  int unsigned         bits_left;
  field_t              field;
  logic [OFF_W-1:0]    match_base;
  logic [LIM_W-1:0]    emitted;
  logic                stream_closed;
  logic [LIM_W-1:0]    limit_reg;

  // Decoded words still owed by the block, oldest first.
  out_word_t decoded_q[$];
  out_word_t held_word;
  bit        held_valid;

  // Code bits of the stream under construction.
  bit code_bits[$];

  int  mismatch_count;
  int  words_sent;
  int  burst_left;
  bit  hold_request;

  lzss_decompressor i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  // The last word of a step gets run_end, so each word is held back one call.
  task automatic queue_word(input logic [7:0] data, input logic has, input logic done);
    if (held_valid) begin
      decoded_q = {decoded_q, held_word};
    end
    held_word.data        = data;
    held_word.has_data    = has;
    held_word.run_end     = 1'b0;
    held_word.stream_done = done;
    held_valid            = 1'b1;
  endtask

  task automatic open_stream();
    ring_pos      = OFF_W'(1);
    bit_acc       = '0;
    bits_left     = 1;
    field         = FIELD_FLAG;
    match_base    = '0;
    emitted       = '0;
    stream_closed = 1'b0;
  endtask

  task automatic begin_field(input field_t next, input int unsigned width);
    field     = next;
    bits_left = width;
    bit_acc   = '0;
  endtask

  // Every output byte also lands in the ring at the current write position.
  task automatic emit_byte(input logic [7:0] value);
    queue_word(value, 1'b1, 1'b0);
    emitted            = emitted + LIM_W'(1);
    dict_mem[ring_pos] = value;
    ring_pos           = ring_pos + OFF_W'(1);
  endtask

  task automatic close_stream();
    queue_word(8'h00, 1'b0, 1'b1);
    stream_closed = 1'b1;
  endtask

  // Feed one code bit to the token parser.
  task automatic shift_bit(input logic code_bit);
    int unsigned      copy_len;
    int unsigned      k;
    logic [OFF_W-1:0] rd_idx;
    bit_acc = {bit_acc[14:0], code_bit};
    if (bits_left > 1) begin
      bits_left--;
      return;
    end
    case (field)
      FIELD_FLAG: begin
        if (bit_acc[0]) begin
          begin_field(FIELD_LITERAL, BYTE_W);
        end else begin
          begin_field(FIELD_OFFSET, OFF_W);
        end
      end
      FIELD_LITERAL: begin
        if (emitted >= limit_reg) begin
          close_stream();
        end else begin
          emit_byte(bit_acc[7:0]);
          begin_field(FIELD_FLAG, 1);
        end
      end
      FIELD_OFFSET: begin
        match_base = bit_acc[OFF_W-1:0];
        if (match_base == '0) begin
          close_stream();
        end else begin
          begin_field(FIELD_LENGTH, LEN_W);
        end
      end
      default: begin
        // Byte by byte, so an overlapping copy reads what it just wrote.
        copy_len = int'(bit_acc[LEN_W-1:0]) + lzd_pkg::MIN_MATCH;
        for (k = 0; k < copy_len && emitted < limit_reg; k++) begin
          rd_idx = match_base + k[OFF_W-1:0];
          emit_byte(dict_mem[rd_idx]);
        end
        begin_field(FIELD_FLAG, 1);
      end
    endcase
  endtask

  // Work out every word caused by one accepted compressed byte.
  task automatic decode_word(input logic [7:0] value, input logic is_final);
    int bit_i;
    int guard;
    if (stream_closed) begin
      open_stream();
    end
    for (bit_i = 7; bit_i >= 0 && !stream_closed; bit_i--) begin
      shift_bit(value[bit_i]);
    end
    // Past the final byte the parser sees zeros until the stream closes.
    if (is_final) begin
      guard = FILL_GUARD;
      while (!stream_closed && guard > 0) begin
        shift_bit(1'b0);
        guard--;
      end
    end
    if (held_valid) begin
      held_word.run_end = 1'b1;
      decoded_q = {decoded_q, held_word};
      held_valid = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one word; bursts of random length are separated by random gaps.
  task automatic send_word(input logic [7:0] value, input logic is_final);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= is_final;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    decode_word(value, is_final);
  endtask

  task automatic add_field(input logic [15:0] value, input int width);
    int k;
    for (k = width - 1; k >= 0; k--) begin
      code_bits = {code_bits, bit'(value[k])};
    end
  endtask

  task automatic add_literal(input logic [7:0] value);
    add_field(16'd1, 1);
    add_field({8'h00, value}, BYTE_W);
  endtask

  task automatic add_match(input int unsigned offset, input int unsigned len);
    add_field(16'd0, 1);
    add_field(offset[15:0], OFF_W);
    add_field(len[15:0], LEN_W);
  endtask

  task automatic add_end_marker();
    add_field(16'd0, 1);
    add_field(16'd0, OFF_W);
  endtask

  // Pad the code bits to whole bytes with random bits and send them.
  task automatic send_packed(input bit mark_last);
    logic [7:0] value;
    int         n_bytes;
    int         i;
    int         k;
    while (code_bits.size() % 8 != 0) begin
      code_bits = {code_bits, bit'($urandom_range(0, 1))};
    end
    n_bytes = code_bits.size() / 8;
    for (i = 0; i < n_bytes; i++) begin
      for (k = 7; k >= 0; k--) begin
        value[k] = code_bits.pop_front();
      end
      send_word(value, mark_last && (i == n_bytes - 1));
    end
  endtask

  // A well-formed stream with random tokens, mostly closed by an end marker.
  task automatic send_random_stream(input int max_tokens);
    int n_tok;
    int t;
    bit with_end;
    int unsigned offset;
    n_tok = $urandom_range(1, max_tokens);
    for (t = 0; t < n_tok; t++) begin
      if ($urandom_range(0, 99) < 55) begin
        add_literal(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 9))
          0:       offset = $urandom_range(1, DICT_DEPTH - 1);
          1:       offset = DICT_DEPTH - 1;
          default: offset = $urandom_range(1, 24);
        endcase
        add_match(offset, $urandom_range(0, (1 << LEN_W) - 1));
      end
    end
    with_end = ($urandom_range(0, 9) != 0);
    if (with_end) begin
      add_end_marker();
    end
    send_packed(with_end ? ($urandom_range(0, 2) == 0) : 1'b1);
  endtask

  // Random bytes; the last one is final so the next stream starts aligned.
  task automatic send_noise();
    int n;
    int i;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      send_word(8'($urandom_range(0, 255)), i == n - 1);
    end
  endtask

  // Drop valid, wait for all owed words, then let any tail of work finish.
  task automatic settle_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_output_limit(input logic [LIM_W-1:0] value);
    settle_block();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    limit_reg    = value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Receiver stalls on its own pattern, plus one long hold-off on request.
  initial begin : ready_pattern
    int run_left;
    int stall_left;
    out_tready = 1'b0;
    run_left   = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                   : $urandom_range(0, 12);
          stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Compare every accepted output word against the oldest owed one.
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word data=%02h user=%b last=%b",
                                  out_tdata, out_tuser, out_tlast));
      end else begin
        want = decoded_q.pop_front();
        if (out_tdata !== want.data) begin
          report_mismatch($sformatf("data_byte %02h, want %02h", out_tdata, want.data));
        end
        if (out_tuser[0] !== want.has_data) begin
          report_mismatch($sformatf("has_data %b, want %b", out_tuser[0], want.has_data));
        end
        if (out_tuser[1] !== want.stream_done) begin
          report_mismatch($sformatf("stream_done %b, want %b", out_tuser[1],
                                    want.stream_done));
        end
        if (out_tlast !== want.run_end) begin
          report_mismatch($sformatf("run_end %b, want %b", out_tlast, want.run_end));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Literal extremes, short and long overlapping copies, far offset, both endings.
  task automatic test_token_kinds();
    write_output_limit(lzd_pkg::LIMIT_RESET);
    add_literal(8'h00);
    add_literal(8'hFF);
    add_match(1, 0);
    add_match(2, (1 << LEN_W) - 1);
    add_match(DICT_DEPTH - 1, 0);
    add_end_marker();
    send_packed(1'b1);
    // No end marker: the zero fill after the final byte closes the stream.
    add_literal(8'hA5);
    send_packed(1'b1);
  endtask

  // Zero limit drops a copy and closes on the next literal; a small one cuts a copy.
  task automatic test_output_limit();
    write_output_limit('0);
    add_match(1, 5);
    add_literal(8'h11);
    add_end_marker();
    send_packed(1'b1);
    write_output_limit(LIM_W'(4));
    add_literal(8'h01);
    add_match(1, 3);
    add_literal(8'h02);
    send_packed(1'b1);
  endtask

  // Random streams over several limits, the largest (reset) value among them.
  task automatic test_random_streams();
    logic [LIM_W-1:0] limits [5];
    int p;
    int phase_start;
    limits[0] = lzd_pkg::LIMIT_RESET;
    limits[1] = LIM_W'($urandom_range(1, 40));
    limits[2] = LIM_W'(2);
    limits[3] = LIM_W'($urandom_range(0, (1 << LIM_W) - 1));
    limits[4] = lzd_pkg::LIMIT_RESET;
    for (p = 0; p < 5; p++) begin
      write_output_limit(limits[p]);
      phase_start = words_sent;
      while (words_sent < phase_start + PHASE_WORDS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_noise();
        end else begin
          send_random_stream(8);
        end
      end
    end
  endtask

  // Long receiver hold-off while input keeps coming, so the block backs up.
  task automatic test_backpressure();
    int start_count;
    settle_block();
    hold_request = 1'b1;
    start_count  = words_sent;
    while (words_sent < start_count + PRESSURE_WORDS) begin
      send_random_stream(6);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    mismatch_count = 0;
    words_sent     = 0;
    burst_left     = 0;
    hold_request   = 1'b0;
    held_valid     = 1'b0;
    held_word      = '0;
    limit_reg      = lzd_pkg::LIMIT_RESET;
    foreach (dict_mem[i]) begin
      dict_mem[i] = '0;
    end
    open_stream();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_token_kinds();
    test_output_limit();
    test_random_streams();
    test_backpressure();

    settle_block();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/lzd_pkg.sv
hw/rtl/lzd_bit_parser.sv
hw/rtl/lzss_decompressor.sv
bench/tb_lzss_decompressor.sv
